// ===== rtl/h264_rtp_payload_depacketizer_top_defines.svh =====
// ---------------------------------------------------------------------------
// h264 rtp depacketizer assertion macros
// shared concurrent check forms, clocked on clk, quiet during reset
// ---------------------------------------------------------------------------
`ifndef H264_RTP_PAYLOAD_DEPACKETIZER_TOP_DEFINES_SVH
`define H264_RTP_PAYLOAD_DEPACKETIZER_TOP_DEFINES_SVH

// same-cycle implication
`define H264RTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define H264RTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/h264rtp_pkg.sv =====
// ---------------------------------------------------------------------------
// h264rtp_pkg
// types and constants shared by the h264 rtp depacketizer modules
// ---------------------------------------------------------------------------
package h264rtp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SINGLE,
        PH_FU_HDR,
        PH_FU_DATA,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_UNIT
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_MALFORMED   = 2'd2,
        ST_TOO_LONG    = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic CFG_EMIT_SC  = 1'b0;
    localparam logic CFG_NAL_CAP  = 1'b1;
    localparam int   CFG_DATA_W   = 16;

    localparam logic [4:0] TYPE_SINGLE_MIN = 5'd1;
    localparam logic [4:0] TYPE_SINGLE_MAX = 5'd23;
    localparam logic [4:0] TYPE_STAP_A     = 5'd24;
    localparam logic [4:0] TYPE_FU_A       = 5'd28;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;
    // start code bytes come at run index 0..3, the unit byte at index 4
    localparam logic [2:0] SC_LAST_IDX  = 3'd3;
    localparam logic [2:0] RUN_BYTE_IDX = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       pkt_first;
        logic       pkt_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_start_code;
        logic       nal_begin;
        status_t    status;
        logic       run_last;
    } out_item_t;

    // one input word's worth of results
    typedef struct packed {
        logic       with_sc;
        logic       nal_begin;
        logic [7:0] data;
        status_t    status;
    } run_desc_t;

endpackage

// ===== rtl/h264rtp_parse.sv =====
// ---------------------------------------------------------------------------
// h264rtp_parse
// packet parser: phase register and per-word result run descriptor
// ---------------------------------------------------------------------------
module h264rtp_parse
    import h264rtp_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  in_item_t        item,
    input  logic            emit_sc,
    input  logic [15:0]     nal_cap,
    output logic            desc_valid,
    output run_desc_t       desc
);

    phase_t                 phase_reg,    phase_next;
    logic                   frag_reg,     frag_next;
    logic                   end_seen_reg, end_seen_next;
    logic [7:0]             ind_reg,      ind_next;
    logic [7:0]             len_hi_reg,   len_hi_next;
    logic [LENGTH_BITS-1:0] remain_reg,   remain_next;
    logic [15:0]            count_reg,    count_next;

    logic [4:0]             nal_type;
    logic                   put;
    logic                   put_ok;
    logic [7:0]             put_byte;
    logic [15:0]            count_base;
    logic                   fail;
    status_t                fail_code;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] remain_dec;

    assign nal_type   = item.in_byte[4:0];
    assign len        = LENGTH_BITS'({len_hi_reg, item.in_byte});
    assign remain_dec = (remain_reg != '0) ? remain_reg - LENGTH_BITS'(1) : remain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            frag_reg     <= 1'b0;
            end_seen_reg <= 1'b0;
            ind_reg      <= '0;
            len_hi_reg   <= '0;
            remain_reg   <= '0;
            count_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            frag_reg     <= frag_next;
            end_seen_reg <= end_seen_next;
            ind_reg      <= ind_next;
            len_hi_reg   <= len_hi_next;
            remain_reg   <= remain_next;
            count_reg    <= count_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        frag_next     = frag_reg;
        end_seen_next = end_seen_reg;
        ind_next      = ind_reg;
        len_hi_next   = len_hi_reg;
        remain_next   = remain_reg;
        count_next    = count_reg;
        put           = 1'b0;
        put_byte      = item.in_byte;
        count_base    = count_reg;
        fail          = 1'b0;
        fail_code     = ST_OK;

        if (item.pkt_first)
        begin
            ind_next    = item.in_byte;
            remain_next = '0;
            if (frag_reg && nal_type != TYPE_FU_A)
            begin
                fail      = 1'b1;
                fail_code = ST_MALFORMED;
            end
            else if (nal_type >= TYPE_SINGLE_MIN && nal_type <= TYPE_SINGLE_MAX)
            begin
                phase_next = PH_SINGLE;
                count_base = '0;
                put        = 1'b1;
            end
            else if (nal_type == TYPE_FU_A || nal_type == TYPE_STAP_A)
            begin
                if (item.pkt_last)
                begin
                    fail      = 1'b1;
                    fail_code = ST_MALFORMED;
                end
                else
                begin
                    phase_next = (nal_type == TYPE_FU_A) ? PH_FU_HDR : PH_LEN_HI;
                end
            end
            else
            begin
                fail      = 1'b1;
                fail_code = ST_UNSUPPORTED;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SINGLE, PH_FU_DATA:
                begin
                    put = 1'b1;
                end
                PH_FU_HDR:
                begin
                    if (item.in_byte[7])
                    begin
                        // start bit: rebuild header from nri and fu type
                        count_base    = '0;
                        put           = 1'b1;
                        put_byte      = {1'b0, ind_reg[6:5], item.in_byte[4:0]};
                        frag_next     = 1'b1;
                        end_seen_next = item.in_byte[6];
                        phase_next    = PH_FU_DATA;
                    end
                    else if (!frag_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_MALFORMED;
                    end
                    else
                    begin
                        end_seen_next = item.in_byte[6];
                        phase_next    = PH_FU_DATA;
                    end
                end
                PH_LEN_HI:
                begin
                    if (item.pkt_last)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_MALFORMED;
                    end
                    else
                    begin
                        len_hi_next = item.in_byte;
                        phase_next  = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    if (len == '0 || item.pkt_last)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_MALFORMED;
                    end
                    else
                    begin
                        remain_next = len;
                        count_next  = '0;
                        phase_next  = PH_UNIT;
                    end
                end
                PH_UNIT:
                begin
                    if (item.pkt_last && remain_reg != LENGTH_BITS'(1))
                    begin
                        fail      = 1'b1;
                        fail_code = ST_MALFORMED;
                    end
                    else
                    begin
                        put         = 1'b1;
                        remain_next = remain_dec;
                        if (remain_dec == '0)
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        put_ok = put && (count_base < nal_cap);
        if (put)
        begin
            count_next = put_ok ? count_base + 16'd1 : count_base;
            if (!put_ok)
            begin
                fail      = 1'b1;
                fail_code = ST_TOO_LONG;
            end
        end

        // an error abandons the packet and any open fragment
        if (fail)
        begin
            phase_next    = PH_IDLE;
            frag_next     = 1'b0;
            end_seen_next = 1'b0;
            remain_next   = '0;
        end

        if (item.pkt_last && phase_next != PH_IDLE)
        begin
            if ((phase_next == PH_FU_DATA || phase_next == PH_FU_HDR) && end_seen_next)
            begin
                frag_next = 1'b0;
            end
            end_seen_next = 1'b0;
            phase_next    = PH_IDLE;
        end

        desc_valid     = fail || put_ok;
        desc.with_sc   = put_ok && emit_sc && (count_base == '0);
        desc.nal_begin = put_ok && (count_base == '0);
        desc.data      = put_ok ? put_byte : 8'h00;
        desc.status    = fail_code;
    end

endmodule

// ===== rtl/h264rtp_emit.sv =====
// ---------------------------------------------------------------------------
// h264rtp_emit
// two-deep run buffer that plays each run out one word per handshake
// ---------------------------------------------------------------------------
`include "h264_rtp_payload_depacketizer_top_defines.svh"

module h264rtp_emit
    import h264rtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  run_desc_t  desc,
    output logic       ready,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    logic       pend_valid_reg, pend_valid_next;
    run_desc_t  pend_reg,       pend_next;
    logic       run_valid_reg,  run_valid_next;
    run_desc_t  run_reg,        run_next;
    logic [2:0] idx_reg,        idx_next;

    logic       last_idx;
    logic       out_fire;
    logic       run_done;
    logic       pend_move;

    assign last_idx  = !run_reg.with_sc || (idx_reg == RUN_BYTE_IDX);
    assign out_fire  = run_valid_reg && !out_stall;
    assign run_done  = out_fire && last_idx;
    assign pend_move = !run_valid_reg || run_done;
    assign ready     = !pend_valid_reg || pend_move;
    assign out_valid = run_valid_reg;

    always_comb
    begin
        if (run_reg.with_sc && idx_reg != RUN_BYTE_IDX)
        begin
            out_data.out_byte      = (idx_reg == SC_LAST_IDX) ? SC_ONE : SC_ZERO;
            out_data.is_start_code = 1'b1;
            out_data.nal_begin     = 1'b0;
            out_data.status        = ST_OK;
            out_data.run_last      = 1'b0;
        end
        else
        begin
            out_data.out_byte      = run_reg.data;
            out_data.is_start_code = 1'b0;
            out_data.nal_begin     = run_reg.nal_begin;
            out_data.status        = run_reg.status;
            out_data.run_last      = 1'b1;
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        run_valid_next  = run_valid_reg;
        run_next        = run_reg;
        idx_next        = idx_reg;

        if (pend_move)
        begin
            run_valid_next = pend_valid_reg;
            run_next       = pend_reg;
            idx_next       = '0;
        end
        else if (out_fire)
        begin
            idx_next = idx_reg + 3'd1;
        end

        if (ready)
        begin
            pend_valid_next = load;
            pend_next       = desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            run_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            run_valid_reg  <= run_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        run_reg  <= run_next;
    end

    `H264RTP_ASSERT_NOW(a_plain_run_idx, run_valid_reg && !run_reg.with_sc, idx_reg == 3'd0, "plain run left index zero")
    `H264RTP_ASSERT_NOW(a_sc_run_last, out_valid && out_data.run_last && run_reg.with_sc, idx_reg == RUN_BYTE_IDX, "start code run ended early")
    `H264RTP_ASSERT_NOW(a_sc_status, out_valid && out_data.is_start_code, out_data.status == ST_OK, "start code word carries an error")
    `H264RTP_ASSERT_NEXT(a_pend_handoff, run_done && pend_valid_reg, run_valid_reg && idx_reg == 3'd0, "pending run not handed over")

endmodule

// ===== rtl/h264_rtp_payload_depacketizer_top.sv =====
// ---------------------------------------------------------------------------
// h264 rtp payload depacketizer
// rtp payload bytes in, annex b byte stream out (single nal, stap-a, fu-a)
// ---------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  cfg       in    cfg_we               cfg_index, cfg_data
//  in        in    in_valid/in_stall    in_data  (in_item_t)
//  out       out   out_valid/out_stall  out_data (out_item_t)
//
// one input word per cycle while in_stall is low; a word that opens a unit with start codes gives
// a run of five output words, all other words give zero or one
// the output side plays out one word per cycle while out_stall is low, from a two-deep run buffer;
// in_stall rises only when that buffer is full and its head is not finishing
// results pass through the pending register and then the run register of that buffer before they appear
// reset brings the parser to idle and the registers to start codes on,
// capacity 65535; no clearing pass
module h264_rtp_payload_depacketizer_top
    import h264rtp_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    logic        emit_sc_reg;
    logic [15:0] nal_cap_reg;
    logic        in_fire;
    logic        ready;
    logic        desc_valid;
    run_desc_t   desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_sc_reg <= 1'b1;
            nal_cap_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EMIT_SC: emit_sc_reg <= cfg_data[0];
                CFG_NAL_CAP: nal_cap_reg <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    assign in_stall = !ready;
    assign in_fire  = in_valid && ready;

    h264rtp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_fire),
        .item       (in_data),
        .emit_sc    (emit_sc_reg),
        .nal_cap    (nal_cap_reg),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    h264rtp_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire && desc_valid),
        .desc      (desc),
        .ready     (ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
